### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: condition must never hold");

// cons must hold at the edge at which ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// cons must hold at the edge after the one at which ante holds
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

### src/ishd_pkg.sv
// ----------------------------------------------------------------------------
// ishd_pkg
// Word types and fixed constants of the half/double image scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ishd_pkg;

  localparam int CH_BITS       = 8;
  localparam int SUM_BITS      = CH_BITS + 1;
  localparam int POS_BITS      = 13;
  localparam int ROW_BITS      = 12;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam int WIDTH_RESET   = 640;
  localparam int JOB_DEPTH     = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_MODE  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 1'b1;

  localparam logic MODE_HALVE  = 1'b0;
  localparam logic MODE_DOUBLE = 1'b1;

  typedef struct packed {
    logic               frame_start;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [CH_BITS-1:0]  out_red;
    logic [CH_BITS-1:0]  out_green;
    logic [CH_BITS-1:0]  out_blue;
    logic [POS_BITS-1:0] out_column;
    logic [POS_BITS-1:0] out_row;
    logic                last_of_run;
  } out_word_t;

  typedef struct packed {
    logic                is_quad;
    logic [CH_BITS-1:0]  red;
    logic [CH_BITS-1:0]  green;
    logic [CH_BITS-1:0]  blue;
    logic [POS_BITS-1:0] base_col;
    logic [POS_BITS-1:0] base_row;
  } job_t;

endpackage

### src/ishd_job_fifo.sv
// ----------------------------------------------------------------------------
// ishd_job_fifo
// Short first-word-fall-through queue of jobs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ishd_job_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  ishd_pkg::job_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output ishd_pkg::job_t  rd_data,
  output logic            empty
);

  localparam int PW = $clog2(ishd_pkg::JOB_DEPTH);

  ishd_pkg::job_t   slot_r [ishd_pkg::JOB_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == (PW+1)'(ishd_pkg::JOB_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    do_wr      = wr_en & ~full;
    do_rd      = rd_en & ~empty;
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### src/ishd_front.sv
// ----------------------------------------------------------------------------
// ishd_front
// Accepts pixels, tracks position, forms pair sums, keeps the line store
// and queues one job for each pixel that gives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ishd_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ishd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ishd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 push,
  output logic                                 full,
  input  ishd_pkg::in_word_t                   in_word,
  output logic                                 job_wr,
  output ishd_pkg::job_t                       job_data,
  input  logic                                 job_full
);

  localparam int CH         = ishd_pkg::CH_BITS;
  localparam int SB         = ishd_pkg::SUM_BITS;
  localparam int PB         = ishd_pkg::POS_BITS;
  localparam int RB         = ishd_pkg::ROW_BITS;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WIDTH_RST  = (ishd_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                   : ishd_pkg::WIDTH_RESET;

  logic                  mode_r, mode_nxt;
  logic [WW-1:0]         weff_r, weff_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RB-1:0]         row_r, row_nxt;
  logic [2:0][CH-1:0]    held_r, held_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_half_r;
  logic [2:0][CH-1:0]    s1_pix_r;
  logic [2:0][SB-1:0]    s1_pair_r;
  logic [PB-1:0]         s1_col_r;
  logic [PB-1:0]         s1_row_r;
  logic [2:0][SB-1:0]    line_rd_r;
  logic [2:0][SB-1:0]    line_mem [LINE_DEPTH];

  logic [13:0]           width_ext;
  logic                  in_acc;
  logic                  halve;
  logic                  gives_result;
  logic                  odd_col, odd_row;
  logic                  wr_line, rd_line;
  logic                  s1_move;
  logic                  wrap;
  logic [CW-1:0]         col_base, col_cur;
  logic [RB-1:0]         row_base;
  logic [CW:0]           weff_ext, col_inc;
  logic [2:0][CH-1:0]    px;
  logic [2:0][SB-1:0]    pair;
  logic [AW-1:0]         line_addr;
  logic [PB-1:0]         res_col, res_row;
  logic [2:0][SB:0]      quad_sum;
  logic [2:0][CH-1:0]    avg;

  // configuration, width clamped once at write
  always_comb begin
    mode_nxt  = mode_r;
    weff_nxt  = weff_r;
    width_ext = {1'b0, cfg_data};
    if (cfg_we) begin
      case (cfg_index)
        ishd_pkg::CFG_SCALE_MODE: begin
          mode_nxt = cfg_data[0];
        end
        ishd_pkg::CFG_IMAGE_WIDTH: begin
          if (width_ext == '0) begin
            weff_nxt = WW'(1);
          end else if (width_ext > 14'(MAX_WIDTH)) begin
            weff_nxt = WW'(MAX_WIDTH);
          end else begin
            weff_nxt = width_ext[WW-1:0];
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // position and classification
  always_comb begin
    in_acc   = push & ~full;
    halve    = (mode_r == ishd_pkg::MODE_HALVE);
    weff_ext = (CW+1)'(weff_r);
    col_base = in_word.frame_start ? '0 : col_r;
    row_base = in_word.frame_start ? '0 : row_r;
    col_cur  = ({1'b0, col_base} >= weff_ext) ? '0 : col_base;
    col_inc  = {1'b0, col_cur} + (CW+1)'(1);
    wrap     = (col_inc >= weff_ext);
    odd_col  = col_cur[0];
    odd_row  = row_base[0];

    px[0] = in_word.red;
    px[1] = in_word.green;
    px[2] = in_word.blue;
    for (int c = 0; c < 3; c++) begin
      pair[c] = {1'b0, held_r[c]} + {1'b0, px[c]};
    end

    line_addr    = AW'(col_cur >> 1);
    wr_line      = in_acc & halve & odd_col & ~odd_row;
    rd_line      = in_acc & halve & odd_col & odd_row;
    gives_result = ~halve | (odd_col & odd_row);

    if (halve) begin
      res_col = PB'(col_cur >> 1);
      res_row = PB'(row_base >> 1);
    end else begin
      res_col = PB'({col_cur, 1'b0});
      res_row = PB'({row_base, 1'b0});
    end

    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    if (in_acc) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = row_base + 1'b1;
      end else begin
        col_nxt = col_inc[CW-1:0];
        row_nxt = row_base;
      end
      if (halve && !odd_col) begin
        held_nxt = px;
      end
    end

    s1_move      = s1_valid_r & ~job_full;
    s1_valid_nxt = (s1_valid_r & ~s1_move) | (in_acc & gives_result);
  end

  assign full   = s1_valid_r & job_full;
  assign job_wr = s1_move;

  // finish the 2x2 average on the registered line read
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quad_sum[c] = {1'b0, line_rd_r[c]} + {1'b0, s1_pair_r[c]};
      avg[c]      = quad_sum[c][SB:2];
    end
    job_data.is_quad  = ~s1_half_r;
    job_data.red      = s1_half_r ? avg[0] : s1_pix_r[0];
    job_data.green    = s1_half_r ? avg[1] : s1_pix_r[1];
    job_data.blue     = s1_half_r ? avg[2] : s1_pix_r[2];
    job_data.base_col = s1_col_r;
    job_data.base_row = s1_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ishd_pkg::MODE_HALVE;
      weff_r     <= WW'(WIDTH_RST);
      col_r      <= '0;
      row_r      <= '0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      weff_r     <= weff_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      held_r     <= held_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && gives_result) begin
      s1_half_r <= halve;
      s1_pix_r  <= px;
      s1_pair_r <= pair;
      s1_col_r  <= res_col;
      s1_row_r  <= res_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_line) begin
      line_mem[line_addr] <= pair;
    end
    if (rd_line) begin
      line_rd_r <= line_mem[line_addr];
    end
  end

endmodule

### src/ishd_back.sv
// ----------------------------------------------------------------------------
// ishd_back
// Expands each queued job into one or four result words and holds the
// oldest one in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ishd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ishd_pkg::job_t      job_data,
  input  logic                job_empty,
  output logic                job_rd,
  output logic                empty,
  input  logic                pop,
  output ishd_pkg::out_word_t out_word
);

  ishd_pkg::out_word_t out_word_r, out_word_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          sub_r, sub_nxt;
  logic                advance;
  logic                is_last;

  assign empty    = ~out_valid_r;
  assign out_word = out_word_r;

  always_comb begin
    advance = ~out_valid_r | pop;
    is_last = ~job_data.is_quad | (sub_r == 2'd3);

    out_word_nxt.out_red     = job_data.red;
    out_word_nxt.out_green   = job_data.green;
    out_word_nxt.out_blue    = job_data.blue;
    out_word_nxt.out_column  = job_data.base_col | ishd_pkg::POS_BITS'(sub_r[0]);
    out_word_nxt.out_row     = job_data.base_row | ishd_pkg::POS_BITS'(sub_r[1]);
    out_word_nxt.last_of_run = is_last;

    job_rd        = advance & ~job_empty & is_last;
    out_valid_nxt = advance ? ~job_empty : out_valid_r;
    sub_nxt       = sub_r;
    if (advance && !job_empty) begin
      sub_nxt = is_last ? 2'd0 : sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !job_empty) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

### src/image_scale_half_double.sv
// ----------------------------------------------------------------------------
// image_scale_half_double
// RGB scaler: halves by 2x2 box averaging or doubles by pixel replication.
//
//   channel  ports                          moves
//   input    push, full, in_word            one pixel per word
//   result   empty, pop, out_word           one scaled pixel per word
//   config   cfg_we, cfg_index, cfg_data    one register per write
//
// Halving takes one pixel per cycle while full is low. In doubling the back end issues
// one result word per cycle from each job while pop is held, four per job, and new
// pixels queue as jobs. Results pass the front stage, job queue and output register.
// Reset clears position counters and queues; the line store is not cleared.
// A stalled result side fills the output register, the four-job queue and the
// front stage, then raises full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module image_scale_half_double #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ishd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ishd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               push,
  output logic                               full,
  input  ishd_pkg::in_word_t                 in_word,
  output logic                               empty,
  input  logic                               pop,
  output ishd_pkg::out_word_t                out_word
);

  ishd_pkg::job_t   job_wr_data;
  ishd_pkg::job_t   job_rd_data;
  logic             job_wr;
  logic             job_full;
  logic             job_rd;
  logic             job_empty;

  ishd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .job_wr    (job_wr),
    .job_data  (job_wr_data),
    .job_full  (job_full)
  );

  ishd_job_fifo u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_wr),
    .wr_data (job_wr_data),
    .full    (job_full),
    .rd_en   (job_rd),
    .rd_data (job_rd_data),
    .empty   (job_empty)
  );

  ishd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_data  (job_rd_data),
    .job_empty (job_empty),
    .job_rd    (job_rd),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

  `ASSERT_NEVER(a_job_overflow, clk, rst_n, job_wr && job_full)
  `ASSERT_NEVER(a_job_underflow, clk, rst_n, job_rd && job_empty)
  `ASSERT_NEXT(a_run_continues, clk, rst_n, !empty && pop && !out_word.last_of_run, !empty)
  `ASSERT_IMPLIES(a_full_needs_queue, clk, rst_n, full, job_full)

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the half/double image scaler. Pixels go in and
// scaled pixels come out through queue handshakes with random gaps on both
// sides. A local model of the scaler predicts every output word, and the
// monitor checks each one against the oldest prediction. Named tests cover
// 2x2 averaging, odd sizes, replication, width changes mid-frame and a
// long random run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_PERIOD    = 10;
  localparam int MAX_W         = 4096;
  localparam int LINE_DEPTH    = MAX_W / 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 280;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic [ishd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [ishd_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic                               push;
  logic                               full;
  ishd_pkg::in_word_t                 in_word;
  logic                               empty;
  logic                               pop;
  ishd_pkg::out_word_t                out_word;

  image_scale_half_double dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // scaler model state
  logic [3*ishd_pkg::SUM_BITS-1:0] pair_line [LINE_DEPTH];
  logic [ishd_pkg::CH_BITS-1:0]    held_r, held_g, held_b;
  logic [ishd_pkg::ROW_BITS-1:0]   col_cnt, row_cnt;
  logic                            mode_q;
  logic [ishd_pkg::POS_BITS-1:0]   width_q;
  ishd_pkg::out_word_t             scaled_q[$];

  // bench state
  int   err_count    = 0;
  int   n_in         = 0;
  int   n_out        = 0;
  int   quiet_cycles = 0;
  bit   took_result  = 1'b0;
  int   tx_idle_max  = 9;
  int   rx_idle_max  = 9;
  logic cur_mode     = ishd_pkg::MODE_HALVE;
  bit   line_valid   = 1'b0;

  function automatic ishd_pkg::out_word_t make_word(
      input logic [ishd_pkg::CH_BITS-1:0] r, g, b,
      input logic [ishd_pkg::POS_BITS-1:0] c, rw,
      input logic last);
    ishd_pkg::out_word_t w;
    w.out_red     = r;
    w.out_green   = g;
    w.out_blue    = b;
    w.out_column  = c;
    w.out_row     = rw;
    w.last_of_run = last;
    return w;
  endfunction

  function automatic logic [ishd_pkg::CH_BITS-1:0] rnd_ch();
    return ishd_pkg::CH_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [ishd_pkg::CH_BITS-1:0] avg4(
      input logic [ishd_pkg::SUM_BITS-1:0] a, b);
    logic [ishd_pkg::SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ishd_pkg::SUM_BITS:2];
  endfunction

  task automatic scale_pixel(input ishd_pkg::in_word_t px);
    int                              w;
    logic [ishd_pkg::ROW_BITS-1:0]   col, row;
    logic [ishd_pkg::SUM_BITS-1:0]   ps_r, ps_g, ps_b;
    logic [3*ishd_pkg::SUM_BITS-1:0] above;
    logic [ishd_pkg::ROW_BITS:0]     nxt;
    if (width_q == 0) w = 1;
    else if (width_q > MAX_W) w = MAX_W;
    else w = int'(width_q);
    if (px.frame_start) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    if (col_cnt >= w) col_cnt = '0;
    col = col_cnt;
    row = row_cnt;
    if (mode_q == ishd_pkg::MODE_HALVE) begin
      if (!col[0]) begin
        held_r = px.red;
        held_g = px.green;
        held_b = px.blue;
      end else begin
        ps_r = {1'b0, held_r} + {1'b0, px.red};
        ps_g = {1'b0, held_g} + {1'b0, px.green};
        ps_b = {1'b0, held_b} + {1'b0, px.blue};
        if (!row[0]) begin
          pair_line[col[ishd_pkg::ROW_BITS-1:1]] = {ps_b, ps_g, ps_r};
        end else begin
          above = pair_line[col[ishd_pkg::ROW_BITS-1:1]];
          scaled_q.push_back(make_word(
              avg4(above[ishd_pkg::SUM_BITS-1:0], ps_r),
              avg4(above[2*ishd_pkg::SUM_BITS-1:ishd_pkg::SUM_BITS], ps_g),
              avg4(above[3*ishd_pkg::SUM_BITS-1:2*ishd_pkg::SUM_BITS], ps_b),
              {2'b00, col[ishd_pkg::ROW_BITS-1:1]},
              {2'b00, row[ishd_pkg::ROW_BITS-1:1]}, 1'b1));
        end
      end
    end else begin
      scaled_q.push_back(make_word(px.red, px.green, px.blue,
                                   {col, 1'b0}, {row, 1'b0}, 1'b0));
      scaled_q.push_back(make_word(px.red, px.green, px.blue,
                                   {col, 1'b1}, {row, 1'b0}, 1'b0));
      scaled_q.push_back(make_word(px.red, px.green, px.blue,
                                   {col, 1'b0}, {row, 1'b1}, 1'b0));
      scaled_q.push_back(make_word(px.red, px.green, px.blue,
                                   {col, 1'b1}, {row, 1'b1}, 1'b1));
    end
    nxt = {1'b0, col} + 1'b1;
    if (nxt >= w) begin
      col_cnt = '0;
      row_cnt = row + 1'b1;
    end else begin
      col_cnt = nxt[ishd_pkg::ROW_BITS-1:0];
    end
  endtask

  task automatic check_field(input string name,
                             input logic [ishd_pkg::POS_BITS-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bit                  busy;
    ishd_pkg::out_word_t want;
    if (!rst_n) begin
      mode_q  = ishd_pkg::MODE_HALVE;
      width_q = ishd_pkg::POS_BITS'(ishd_pkg::WIDTH_RESET);
      col_cnt = '0;
      row_cnt = '0;
      held_r  = '0;
      held_g  = '0;
      held_b  = '0;
    end else begin
      busy = 1'b0;
      if (cfg_we) begin
        if (cfg_index == ishd_pkg::CFG_SCALE_MODE) mode_q = cfg_data[0];
        else if (cfg_index == ishd_pkg::CFG_IMAGE_WIDTH) width_q = cfg_data;
        busy = 1'b1;
      end
      if (push && !full) begin
        scale_pixel(in_word);
        n_in++;
        busy = 1'b1;
      end
      if (pop && !empty) begin
        if (scaled_q.size() == 0) begin
          $error("unexpected output word: column %0d row %0d",
                 out_word.out_column, out_word.out_row);
          err_count++;
        end else begin
          want = scaled_q.pop_front();
          check_field("out_red", ishd_pkg::POS_BITS'(want.out_red),
                      ishd_pkg::POS_BITS'(out_word.out_red));
          check_field("out_green", ishd_pkg::POS_BITS'(want.out_green),
                      ishd_pkg::POS_BITS'(out_word.out_green));
          check_field("out_blue", ishd_pkg::POS_BITS'(want.out_blue),
                      ishd_pkg::POS_BITS'(out_word.out_blue));
          check_field("out_column", want.out_column, out_word.out_column);
          check_field("out_row", want.out_row, out_word.out_row);
          check_field("last_of_run", ishd_pkg::POS_BITS'(want.last_of_run),
                      ishd_pkg::POS_BITS'(out_word.last_of_run));
        end
        n_out++;
        took_result = 1'b1;
        busy = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : pop_driver
    int hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (took_result) begin
        took_result = 1'b0;
        hold = $urandom_range(0, rx_idle_max);
      end
      if (!rst_n) pop <= 1'b0;
      else if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else pop <= 1'b1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_pixel(input logic fs,
                            input logic [ishd_pkg::CH_BITS-1:0] r, g, b);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    // a halving odd row must follow its even row in the same settings
    if (cur_mode == ishd_pkg::MODE_HALVE && !line_valid) fs = 1'b1;
    if (cur_mode == ishd_pkg::MODE_HALVE && fs) line_valid = 1'b1;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_word <= '{frame_start: fs, red: r, green: g, blue: b};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (scaled_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ishd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [ishd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == ishd_pkg::CFG_SCALE_MODE) cur_mode = data[0];
    line_valid = 1'b0;
  endtask

  task automatic set_config(input logic m,
                            input logic [ishd_pkg::CFG_DATA_BITS-1:0] w);
    write_reg(ishd_pkg::CFG_SCALE_MODE, {{(ishd_pkg::CFG_DATA_BITS-1){1'b0}}, m});
    write_reg(ishd_pkg::CFG_IMAGE_WIDTH, w);
  endtask

  task automatic test_halve_basic();
    settle();
    set_config(ishd_pkg::MODE_HALVE, ishd_pkg::CFG_DATA_BITS'(4));
    send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd0,   8'd0,   8'd0);
    send_pixel(1'b0, 8'd0,   8'd255, 8'd0);
    // hold the sender until the queue has drained
    settle();
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd0,   8'd0,   8'd255);
    send_pixel(1'b0, 8'd1,   8'd2,   8'd3);
  endtask

  task automatic test_halve_odd_size();
    int k;
    settle();
    set_config(ishd_pkg::MODE_HALVE, ishd_pkg::CFG_DATA_BITS'(3));
    for (k = 0; k < 9; k++)
      send_pixel(k == 0, rnd_ch(), rnd_ch(), rnd_ch());
  endtask

  task automatic test_double_basic();
    settle();
    set_config(ishd_pkg::MODE_DOUBLE, ishd_pkg::CFG_DATA_BITS'(2));
    send_pixel(1'b1, 8'd255, 8'd0,   8'd255);
    send_pixel(1'b0, 8'd0,   8'd255, 8'd0);
    send_pixel(1'b0, 8'd128, 8'd64,  8'd32);
  endtask

  task automatic test_width_change_in_frame();
    int k;
    settle();
    set_config(ishd_pkg::MODE_DOUBLE, ishd_pkg::CFG_DATA_BITS'(6));
    for (k = 0; k < 4; k++)
      send_pixel(k == 0, rnd_ch(), rnd_ch(), rnd_ch());
    settle();
    write_reg(ishd_pkg::CFG_IMAGE_WIDTH, ishd_pkg::CFG_DATA_BITS'(2));
    for (k = 0; k < 3; k++)
      send_pixel(1'b0, rnd_ch(), rnd_ch(), rnd_ch());
  endtask

  task automatic test_random();
    int   sent, w, h, len, k, pause_at;
    logic m, broken, fs;
    sent = 0;
    w    = 1;
    while (sent < RANDOM_ITEMS) begin
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      if (sent == 0 || $urandom_range(0, 3) != 0) begin
        settle();
        m = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = $urandom_range(13, 40);
          default: w = $urandom_range(1, 12);
        endcase
        set_config(m, ishd_pkg::CFG_DATA_BITS'(w));
      end
      h   = (w > 12) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      len = ((w == 0) ? 1 : w) * h;
      broken = ($urandom_range(0, 4) == 0);
      if (broken) len = $urandom_range(1, len + 3);
      pause_at = ($urandom_range(0, 5) == 0) ? len / 2 : -1;
      for (k = 0; k < len; k++) begin
        fs = (k == 0) ? (!broken || $urandom_range(0, 1))
                      : (broken && $urandom_range(0, 7) == 0);
        if (k == pause_at) settle();
        send_pixel(fs, rnd_ch(), rnd_ch(), rnd_ch());
        sent++;
      end
    end
    tx_idle_max = 9;
    rx_idle_max = 9;
  endtask

  initial begin
    rst_n     = 1'b0;
    push      = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_word   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_halve_basic();
    test_halve_odd_size();
    test_double_basic();
    test_width_change_in_frame();
    test_random();
    settle();
    $display("Covered halving and doubling at widths 0 to 40, odd sizes, broken frames");
    $display("and mid-frame width changes: %0d pixels in, %0d pixels out", n_in, n_out);
    if (err_count == 0 && scaled_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### image_scale_half_double.f
+incdir+src
src/ishd_pkg.sv
src/ishd_job_fifo.sv
src/ishd_front.sv
src/ishd_back.sv
src/image_scale_half_double.sv
tb/tb_top.sv
